// ===== rtl/alle_pkg.sv =====
// Package for the array linked list engine.
// Holds the capacity, the link and index widths, and the request and status codes.
// Depends on nothing; the top level and the testbench import it.
package alle_pkg;

  localparam int CAPACITY = 16;
  localparam int LINK_W   = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;

  // The null link is the first code past the last slot.
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(CAPACITY);

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_CONTAINS   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

endpackage

// ===== rtl/alle_ram.sv =====
// Generic single-port RAM with a registered read.
// Used for the slot value store; depends on nothing.
module alle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled; the output register always takes the word held before the edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/array_linked_list_engine.sv =====
// Array linked list engine: singly linked list of signed 32-bit values with a free list.
// A push when full or a pop when empty goes straight to the response state; push front,
// pop and push back onto an empty list first pass through the take or pop state; push back
// onto a non-empty list then walks the links to the tail, and contains walks the list.
// Takes one transaction at a time: a request is accepted only in the idle state.
// Reset (synchronous): empty list, all slots chained on the free list, no result pending.
module array_linked_list_engine
  import alle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] value
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [1:0] status, [2] found, [7:3] count,
                                     // [8] is_empty, [15:9] zero
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_TAIL,
    S_POP,
    S_SEARCH,
    S_RESP
  } state_t;

  state_t               state;
  req_t                 req;
  logic [VALUE_W-1:0]   value;
  logic [LINK_W-1:0]    link [CAPACITY];
  logic [LINK_W-1:0]    head;
  logic [LINK_W-1:0]    free;
  logic [LINK_W-1:0]    cnt;
  logic [LINK_W-1:0]    cur;
  logic [LINK_W-1:0]    slot;
  logic [LINK_W-1:0]    steps;
  logic                 pend;
  status_t              res_status;
  logic                 res_found;
  status_t              out_status;
  logic                 out_found;
  logic [COUNT_W-1:0]   out_count;
  logic                 out_empty;

  logic [IDX_W-1:0]     link_addr;
  logic [LINK_W-1:0]    rd_link;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_addr;
  logic [VALUE_W-1:0]   ram_rdata;
  logic                 s_acc;
  logic                 out_free;
  logic                 can_issue;
  logic                 match;

  assign s_axis_tready = (state == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // One link read port, addressed by the current step of the sequencer.
  always_comb begin
    case (state)
      S_TAKE:  link_addr = free[IDX_W-1:0];
      S_POP:   link_addr = head[IDX_W-1:0];
      default: link_addr = cur[IDX_W-1:0];
    endcase
  end
  assign rd_link = link[link_addr];

  // The value store is written when a slot is taken and read during a search.
  assign ram_we   = (state == S_TAKE);
  assign ram_addr = (state == S_TAKE) ? free[IDX_W-1:0] : cur[IDX_W-1:0];

  alle_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (value),
    .rdata (ram_rdata)
  );

  // Search step: compare the word fetched last cycle, or fetch the next one.
  assign can_issue = (steps < LINK_NULL) && (cur < LINK_NULL);
  assign match     = pend && (ram_rdata == value);

  // Sequencer, list registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= LINK_NULL;
      free          <= '0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
      pend          <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        link[i] <= LINK_W'(i + 1);
      end
    end else begin
      // A new result loaded in the response state takes the place of the one leaving.
      if (m_axis_tvalid && m_axis_tready && (state != S_RESP)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            req        <= req_t'(s_axis_tuser);
            value      <= s_axis_tdata;
            res_found  <= 1'b0;
            cur        <= head;
            steps      <= '0;
            pend       <= 1'b0;
            case (req_t'(s_axis_tuser))
              REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (free < LINK_NULL) begin
                  res_status <= STAT_DONE;
                  state      <= S_TAKE;
                end else begin
                  res_status <= STAT_FULL;
                  state      <= S_RESP;
                end
              end
              REQ_POP_FRONT: begin
                if (head < LINK_NULL) begin
                  res_status <= STAT_DONE;
                  state      <= S_POP;
                end else begin
                  res_status <= STAT_EMPTY;
                  state      <= S_RESP;
                end
              end
              default: begin
                res_status <= STAT_DONE;
                state      <= S_SEARCH;
              end
            endcase
          end
        end
        S_TAKE: begin
          // The value is written through the RAM port in this cycle.
          slot <= free;
          free <= rd_link;
          cnt  <= cnt + 1'b1;
          if (req == REQ_PUSH_FRONT) begin
            link[free[IDX_W-1:0]] <= head;
            head                  <= free;
            state                 <= S_RESP;
          end else begin
            link[free[IDX_W-1:0]] <= LINK_NULL;
            if (head < LINK_NULL) begin
              state <= S_TAIL;
            end else begin
              head  <= free;
              state <= S_RESP;
            end
          end
        end
        S_TAIL: begin
          // Walk to the tail, then hook the new slot behind it.
          if ((steps < LINK_NULL) && (rd_link < LINK_NULL)) begin
            cur   <= rd_link;
            steps <= steps + 1'b1;
          end else begin
            link[cur[IDX_W-1:0]] <= slot;
            state                <= S_RESP;
          end
        end
        S_POP: begin
          head                  <= rd_link;
          link[head[IDX_W-1:0]] <= free;
          free                  <= head;
          if (cnt != '0) begin
            cnt <= cnt - 1'b1;
          end
          state <= S_RESP;
        end
        S_SEARCH: begin
          if (match) begin
            res_found <= 1'b1;
            state     <= S_RESP;
          end else if (can_issue) begin
            cur   <= rd_link;
            steps <= steps + 1'b1;
            pend  <= 1'b1;
          end else begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          // Load the result once the output register is free.
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_status    <= res_status;
            out_found     <= res_found;
            out_count     <= COUNT_W'(cnt);
            out_empty     <= (cnt == '0);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, out_empty, out_count, out_found, out_status};

endmodule

// ===== tb/sv/array_linked_list_engine_tb.sv =====
// Self-checking testbench for the array linked list engine.
// Predicts every result from its own list and free-list model and checks it field by field.
// Depends on alle_pkg and the array_linked_list_engine RTL.
module array_linked_list_engine_tb
  import alle_pkg::*;
();

  typedef struct {
    status_t    status;
    logic       found;
    logic [4:0] count;
    logic       is_empty;
  } list_result_t;

  localparam int EXP_DEPTH = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // [31:0] value
  logic [1:0]  s_axis_tuser = '0;  // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // [1:0] status, [2] found, [7:3] count, [8] is_empty

  // Predicted list state.
  logic [31:0]       value_of[CAPACITY];
  logic [LINK_W-1:0] link_of[CAPACITY];
  logic [LINK_W-1:0] list_head;
  logic [LINK_W-1:0] free_head;
  int                elem_count;

  // Predicted results waiting for their transaction, oldest at the read count.
  list_result_t exp_fifo[EXP_DEPTH];
  int           exp_wr = 0;
  int           exp_rd = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int full_seen      = 0;
  int empty_seen     = 0;
  int found_seen     = 0;

  array_linked_list_engine u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with a period of 2.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one request to the predicted list and returns the result it should produce.
  function automatic list_result_t apply_list_request(req_t kind, logic [31:0] val);
    list_result_t      r;
    logic [LINK_W-1:0] slot;
    logic [LINK_W-1:0] cur;
    int                steps;
    r.status = STAT_DONE;
    r.found  = 1'b0;
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (free_head >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          slot = free_head;
          free_head = link_of[slot];
          value_of[slot] = val;
          if (kind == REQ_PUSH_FRONT) begin
            link_of[slot] = list_head;
            list_head = slot;
          end else begin
            link_of[slot] = LINK_NULL;
            if (list_head >= CAPACITY) begin
              list_head = slot;
            end else begin
              // Walk to the tail, bounded by the capacity.
              cur = list_head;
              steps = 0;
              while (steps < CAPACITY && link_of[cur] < CAPACITY) begin
                cur = link_of[cur];
                steps++;
              end
              link_of[cur] = slot;
            end
          end
          elem_count++;
        end
      end
      REQ_POP_FRONT: begin
        if (list_head >= CAPACITY) begin
          r.status = STAT_EMPTY;
        end else begin
          slot = list_head;
          list_head = link_of[slot];
          link_of[slot] = free_head;
          free_head = slot;
          if (elem_count > 0) elem_count--;
        end
      end
      default: begin
        // Search from the head; any code past the last slot ends the walk.
        cur = list_head;
        for (steps = 0; steps < CAPACITY && cur < CAPACITY && !r.found; steps++) begin
          if (value_of[cur] == val) r.found = 1'b1;
          else cur = link_of[cur];
        end
      end
    endcase
    r.count    = elem_count[4:0];
    r.is_empty = (elem_count == 0);
    return r;
  endfunction

  // Returns the value held k places behind the head of the predicted list.
  function automatic logic [31:0] list_value_at(int k);
    logic [LINK_W-1:0] cur;
    cur = list_head;
    repeat (k) cur = link_of[cur];
    return value_of[cur];
  endfunction

  // Mixes extremes, a small pool that yields duplicates, and full-range values.
  function automatic logic [31:0] random_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      case ($urandom_range(4))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        3: return 32'h7FFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end else if (pick < 45) begin
      return 32'($urandom_range(7));
    end
    return $urandom;
  endfunction

  // Sends one request and records its predicted result once it is accepted.
  task automatic send_request(req_t kind, logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    exp_fifo[exp_wr % EXP_DEPTH] = apply_list_request(kind, val);
    exp_wr++;
    requests_sent++;
  endtask

  task automatic check_field(string field, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Receiver: random back-pressure, and each result transaction checked against the oldest
  // prediction.
  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (exp_wr == exp_rd) begin
        $display("%0t: unexpected result, got 0x%04h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        exp_r = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        check_field("status", exp_r.status, m_axis_tdata[1:0]);
        check_field("found", exp_r.found, m_axis_tdata[2]);
        check_field("count", exp_r.count, m_axis_tdata[7:3]);
        check_field("is_empty", exp_r.is_empty, m_axis_tdata[8]);
        if (exp_r.status == STAT_FULL) full_seen++;
        if (exp_r.status == STAT_EMPTY) empty_seen++;
        if (exp_r.found) found_seen++;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Edge cases: empty list, extremes, a full walk to the tail, pushes into a full list.
  task automatic test_directed_cases();
    send_request(REQ_POP_FRONT, 32'h0000_0000);
    send_request(REQ_CONTAINS, 32'h0000_0000);
    send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    send_request(REQ_PUSH_FRONT, 32'h8000_0000);
    send_request(REQ_PUSH_BACK, 32'hFFFF_FFFF);
    send_request(REQ_PUSH_BACK, 32'h0000_0000);
    send_request(REQ_CONTAINS, 32'hFFFF_FFFF);
    send_request(REQ_CONTAINS, 32'h0000_0001);
    for (int i = 0; i < CAPACITY - 4; i++) send_request(REQ_PUSH_BACK, 32'(100 + i));
    send_request(REQ_PUSH_FRONT, 32'h5A5A_5A5A);
    send_request(REQ_PUSH_BACK, 32'hA5A5_A5A5);
    send_request(REQ_CONTAINS, 32'(100 + CAPACITY - 5));
    send_request(REQ_POP_FRONT, 32'h0000_0000);
    send_request(REQ_CONTAINS, 32'h8000_0000);
  endtask

  // Random traffic that alternates between filling and draining the list, so that the full
  // and empty cases come up often.
  task automatic run_random_requests(int n);
    bit          filling;
    int          roll;
    req_t        kind;
    logic [31:0] val;
    filling = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (elem_count == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
      else if (elem_count == 0 && $urandom_range(3) == 0) filling = 1'b1;
      else if ($urandom_range(99) < 3) filling = !filling;
      roll = $urandom_range(99);
      if (roll < 25) kind = REQ_CONTAINS;
      else if ((roll < 80) == filling)
        kind = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      else kind = REQ_POP_FRONT;
      val = random_value();
      if (kind == REQ_CONTAINS && elem_count > 0 && $urandom_range(99) < 60)
        val = list_value_at($urandom_range(elem_count - 1));
      send_request(kind, val);
    end
  endtask

  task automatic test_random_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_requests(235);
  endtask

  task automatic test_random_sender_gaps();
    send_idle_pct  = 53;
    recv_stall_pct = 0;
    run_random_requests(235);
  endtask

  task automatic test_random_receiver_stalls();
    send_idle_pct  = 0;
    recv_stall_pct = 53;
    run_random_requests(235);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    run_random_requests(235);
  endtask

  initial begin
    int guard;
    for (int i = 0; i < CAPACITY; i++) begin
      value_of[i] = '0;
      link_of[i]  = LINK_W'(i + 1);
    end
    list_head  = LINK_NULL;
    free_head  = '0;
    elem_count = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_no_idle();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();
    s_axis_tvalid <= 1'b0;

    // Let the outstanding results drain, then allow for the longest walk.
    guard = 0;
    while ((exp_wr - exp_rd) != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (CAPACITY + 8) @(posedge clk);
    if ((exp_wr - exp_rd) != 0) begin
      $display("%0t: %0d expected results never arrived", $time, exp_wr - exp_rd);
      mismatch_count++;
    end

    $display("Covered %0d requests and %0d results under four idle and stall mixes.",
             requests_sent, results_seen);
    $display("Pushes into a full list: %0d, pops from an empty list: %0d, hits: %0d.",
             full_seen, empty_seen, found_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
